@@ sv/rpls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpls_pkg
// shared types and constants of the row profile line segmenter
// ----------------------------------------------------------------------------
package rpls_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int MAX_WIDTH = 1024;

    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 11;

    // per-row count saturates at the smaller of the row width and the counter range
    localparam int COUNT_LIMIT = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int LAST_ROW    = ((MAX_ROWS > 1024) ? 1024 : MAX_ROWS) - 1;

    localparam logic [7:0] FG_PIXEL = 8'd255;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [CFG_IW-1:0] {
        CFG_ENTER      = 3'd0,
        CFG_LEAVE      = 3'd1,
        CFG_MIN_RUN    = 3'd2,
        CFG_MIN_HEIGHT = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] enter_threshold;
        logic [CNT_W-1:0] leave_threshold;
        logic [IDX_W-1:0] min_run_before_close;
        logic [IDX_W-1:0] min_line_height;
    } cfg_t;

    // one finished row (or a bare frame end) handed to the tracker
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             row_end;
        logic             frame_end;
    } row_rec_t;

    typedef struct packed {
        logic signed [10:0] line_top;
        logic        [10:0] line_height;
    } res_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

@@ sv/row_profile_line_segmenter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_profile_line_segmenter
// text line finder over the per-row count of foreground pixels
// ----------------------------------------------------------------------------
// a row-end item is stored in the row queue and its line result in the result queue
// throughput: 1 pixel item per cycle unless full; the tracker takes one row record per cycle while
// the result queue has room; full rises only when the 4-entry row queue backs up behind it
// reset: async active low, clears counts, tracker and queues, thresholds go to
// 10 / 10 / 5 / 10; cfg_ready is always high
module row_profile_line_segmenter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          pixel,
    input  logic                                row_end,
    input  logic                                frame_end,
    input  logic                                push,
    output logic                                full,
    output logic signed [10:0]                  line_top,
    output logic [10:0]                         line_height,
    output logic                                empty,
    input  logic                                pop,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpls_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [rpls_pkg::CFG_DW-1:0]         cfg_data
);

    rpls_pkg::cfg_t     cfg_reg;
    rpls_pkg::cfg_t     cfg_next;
    rpls_pkg::row_rec_t rec_in;
    rpls_pkg::row_rec_t rec_out;
    rpls_pkg::q_stat_t  rq_stat;
    rpls_pkg::res_t     res;
    logic               accept;
    logic               rec_push;
    logic               rec_pop;

    assign cfg_ready = 1'b1;
    assign full      = rq_stat.full;
    assign accept    = push && !rq_stat.full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rpls_pkg::CFG_ENTER:      cfg_next.enter_threshold      = cfg_data;
                rpls_pkg::CFG_LEAVE:      cfg_next.leave_threshold      = cfg_data;
                rpls_pkg::CFG_MIN_RUN:
                    cfg_next.min_run_before_close = cfg_data[rpls_pkg::IDX_W-1:0];
                rpls_pkg::CFG_MIN_HEIGHT:
                    cfg_next.min_line_height      = cfg_data[rpls_pkg::IDX_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enter_threshold      <= rpls_pkg::CNT_W'(10);
            cfg_reg.leave_threshold      <= rpls_pkg::CNT_W'(10);
            cfg_reg.min_run_before_close <= rpls_pkg::IDX_W'(5);
            cfg_reg.min_line_height      <= rpls_pkg::IDX_W'(10);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rpls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pixel     (pixel),
        .row_end   (row_end),
        .frame_end (frame_end),
        .rec_push  (rec_push),
        .rec       (rec_in)
    );

    rpls_rowq u_rowq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rec_push),
        .wr_data (rec_in),
        .rd      (rec_pop),
        .rd_data (rec_out),
        .stat    (rq_stat)
    );

    rpls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec_valid (!rq_stat.empty),
        .rec       (rec_out),
        .rec_pop   (rec_pop),
        .res_pop   (pop),
        .res       (res),
        .res_empty (empty)
    );

    assign line_top    = res.line_top;
    assign line_height = res.line_height;

`ifndef SYNTHESIS
    // a row record is queued exactly for accepted items that end a row or a frame
    a_rec_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (row_end || frame_end)) == rec_push)
        else $error("row record push does not match accepted row/frame end");

    // the tracker never takes a record from an empty row queue
    a_rec_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> !rq_stat.empty)
        else $error("tracker popped an empty row queue");

    // a reported line spans at least three rows
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (line_height > 11'd2))
        else $error("reported line height too small");
`endif

endmodule

@@ sv/rpls_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpls_front
// per-row foreground counter, emits one row record per row or frame end
// ----------------------------------------------------------------------------
module rpls_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          pixel,
    input  logic                row_end,
    input  logic                frame_end,
    output logic                rec_push,
    output rpls_pkg::row_rec_t  rec
);

    logic [rpls_pkg::CNT_W-1:0] count_reg;
    logic [rpls_pkg::CNT_W-1:0] count_next;
    logic [rpls_pkg::CNT_W-1:0] count_inc;

    always_comb
    begin
        count_inc = count_reg;
        if ((pixel == rpls_pkg::FG_PIXEL) &&
            (count_reg < rpls_pkg::CNT_W'(rpls_pkg::COUNT_LIMIT)))
        begin
            count_inc = count_reg + 1'b1;
        end

        count_next = count_reg;
        if (accept)
        begin
            count_next = (row_end || frame_end) ? '0 : count_inc;
        end

        rec_push      = accept && (row_end || frame_end);
        rec.count     = count_inc;
        rec.row_end   = row_end;
        rec.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/rpls_rowq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpls_rowq
// short queue of row records between the counter and the tracker
// ----------------------------------------------------------------------------
module rpls_rowq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  rpls_pkg::row_rec_t  wr_data,
    input  logic                rd,
    output rpls_pkg::row_rec_t  rd_data,
    output rpls_pkg::q_stat_t   stat
);

    rpls_pkg::row_rec_t             mem_reg [rpls_pkg::RQ_DEPTH];
    logic [rpls_pkg::RQ_PTR_W-1:0]  wptr_reg;
    logic [rpls_pkg::RQ_PTR_W-1:0]  wptr_next;
    logic [rpls_pkg::RQ_PTR_W-1:0]  rptr_reg;
    logic [rpls_pkg::RQ_PTR_W-1:0]  rptr_next;
    logic [rpls_pkg::RQ_CNT_W-1:0]  cnt_reg;
    logic [rpls_pkg::RQ_CNT_W-1:0]  cnt_next;

    always_comb
    begin
        stat.empty = (cnt_reg == '0);
        stat.full  = (cnt_reg == rpls_pkg::RQ_CNT_W'(rpls_pkg::RQ_DEPTH));
        rd_data    = mem_reg[rptr_reg];

        wptr_next = wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/rpls_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpls_back
// line tracker, one row record per cycle if the 2-entry result queue has room
// ----------------------------------------------------------------------------
module rpls_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rpls_pkg::cfg_t      cfg,
    input  logic                rec_valid,
    input  rpls_pkg::row_rec_t  rec,
    output logic                rec_pop,
    input  logic                res_pop,
    output rpls_pkg::res_t      res,
    output logic                res_empty
);

    logic [rpls_pkg::IDX_W-1:0]     idx_reg;
    logic [rpls_pkg::IDX_W-1:0]     idx_next;
    logic [rpls_pkg::IDX_W-1:0]     start_reg;
    logic [rpls_pkg::IDX_W-1:0]     start_next;
    logic                           in_line_reg;
    logic                           in_line_next;
    logic [rpls_pkg::IDX_W-1:0]     run;
    logic                           emit;
    rpls_pkg::res_t                 new_res;

    rpls_pkg::res_t                 oq_reg [rpls_pkg::OQ_DEPTH];
    logic [rpls_pkg::OQ_PTR_W-1:0]  oq_wptr_reg;
    logic [rpls_pkg::OQ_PTR_W-1:0]  oq_wptr_next;
    logic [rpls_pkg::OQ_PTR_W-1:0]  oq_rptr_reg;
    logic [rpls_pkg::OQ_PTR_W-1:0]  oq_rptr_next;
    logic [rpls_pkg::OQ_CNT_W-1:0]  oq_cnt_reg;
    logic [rpls_pkg::OQ_CNT_W-1:0]  oq_cnt_next;
    logic                           oq_wr;
    logic                           oq_rd;

    always_comb
    begin
        rec_pop = rec_valid &&
                  (oq_cnt_reg != rpls_pkg::OQ_CNT_W'(rpls_pkg::OQ_DEPTH));
        run     = idx_reg - start_reg;
        emit    = 1'b0;

        idx_next     = idx_reg;
        start_next   = start_reg;
        in_line_next = in_line_reg;

        if (rec_pop && rec.row_end)
        begin
            if (!in_line_reg && (rec.count > cfg.enter_threshold))
            begin
                in_line_next = 1'b1;
                start_next   = idx_reg;
            end
            else if (in_line_reg && (run > cfg.min_run_before_close) &&
                     (rec.count < cfg.leave_threshold))
            begin
                in_line_next = 1'b0;
                emit         = (run > cfg.min_line_height);
            end
            if (idx_reg < rpls_pkg::IDX_W'(rpls_pkg::LAST_ROW))
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        // frame end wipes the tracker after the row itself was tracked
        if (rec_pop && rec.frame_end)
        begin
            idx_next     = '0;
            start_next   = '0;
            in_line_next = 1'b0;
        end

        new_res.line_top    = $signed({1'b0, start_reg} - 11'd1);
        new_res.line_height = {1'b0, run} + 11'd2;

        oq_wr = emit;
        oq_rd = res_pop && (oq_cnt_reg != '0);

        oq_wptr_next = oq_wr ? oq_wptr_reg + 1'b1 : oq_wptr_reg;
        oq_rptr_next = oq_rd ? oq_rptr_reg + 1'b1 : oq_rptr_reg;
        oq_cnt_next  = oq_cnt_reg;
        if (oq_wr && !oq_rd)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (oq_rd && !oq_wr)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end

        res_empty = (oq_cnt_reg == '0);
        res       = oq_reg[oq_rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            start_reg   <= '0;
            in_line_reg <= 1'b0;
            oq_wptr_reg <= '0;
            oq_rptr_reg <= '0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            start_reg   <= start_next;
            in_line_reg <= in_line_next;
            oq_wptr_reg <= oq_wptr_next;
            oq_rptr_reg <= oq_rptr_next;
            oq_cnt_reg  <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_reg[oq_wptr_reg] <= new_res;
        end
    end

endmodule
